// ===== src/aes_pkg.sv =====
`default_nettype none

package aes_pkg;

	// Field and port widths
	localparam int HALF_W       = 64;
	localparam int BLOCK_W      = 128;
	localparam int WORD_W       = 32;
	localparam int CFG_INDEX_W  = 4;
	localparam int CFG_DATA_W   = 64;
	localparam int NUM_KEY_REGS = 4;
	localparam int ROUNDS_DEFAULT = 14;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0 = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1 = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2 = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3 = 4'd3;

	// Reduction constant of the field polynomial and the first Rcon byte
	localparam logic [7:0] POLY_RED  = 8'h1b;
	localparam logic [7:0] RCON_INIT = 8'h01;

	typedef struct packed {
		logic [HALF_W-1:0] plain_high;
		logic [HALF_W-1:0] plain_low;
	} plain_item_t;

	typedef struct packed {
		logic [HALF_W-1:0] cipher_high;
		logic [HALF_W-1:0] cipher_low;
	} cipher_item_t;

	// Forward substitution box, entry 0 leftmost.
	localparam logic [0:255][7:0] SBOX = {
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiplication by x in GF(2^8).
	function automatic logic [7:0] xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? POLY_RED : 8'h00);
	endfunction

	// Substitution of each byte of a 32-bit word.
	function automatic logic [WORD_W-1:0] sub_word(logic [WORD_W-1:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// One cipher round without the key addition. Byte 0 is most significant,
	// byte (row, col) sits at 4*col+row.
	function automatic logic [BLOCK_W-1:0] enc_round(logic [BLOCK_W-1:0] din, logic mix);
		logic [0:15][7:0] s;
		logic [0:15][7:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		s = din;
		for (int i = 0; i < 16; i++) begin
			t[i] = SBOX[s[i]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				s[4*c+i] = t[4*((c+i)&3)+i];
			end
		end
		if (mix) begin
			for (int c = 0; c < 4; c++) begin
				a0  = s[4*c];
				a1  = s[4*c+1];
				a2  = s[4*c+2];
				a3  = s[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				s[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				s[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				s[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				s[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== src/aes256_block_encrypt.sv =====
// AES-256 block encryption, one 128-bit block per item.
// Plaintext items come in on plain_valid/plain_stall/plain_item and ciphertext
// items leave on cipher_valid/cipher_stall/cipher_item, in the same order.
// An item is taken at a clock edge with valid high and stall low.
// The key is loaded through cfg_wr_en/cfg_index/cfg_data, indexes 0 to 3 for
// key bytes 0-7, 8-15, 16-23 and 24-31; other indexes are ignored.
// Each key write, and reset, starts the round key expansion, which builds one
// round key per cycle and holds plain_stall high until the last round key is built.
// The datapath is a row of 14 round cells, one full round each, with the
// first key addition folded into the first cell. A block passes through the cells in order and leaves
// from the last cell, and a new block can be taken every cycle while plain_stall is low.
// When the receiver stalls, the result waits in the last cell and items keep
// moving up behind it until every cell holds one; only then, or during key expansion, is plain_stall
// raised. Reset empties all cells and loads the all-zero key.
`default_nettype none

module aes256_block_encrypt #(
	parameter int ROUNDS = aes_pkg::ROUNDS_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               plain_valid,
	output logic                                    plain_stall,
	input  wire aes_pkg::plain_item_t               plain_item,
	output logic                                    cipher_valid,
	input  wire logic                               cipher_stall,
	output aes_pkg::cipher_item_t                   cipher_item,
	input  wire logic                               cfg_wr_en,
	input  wire logic [aes_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [aes_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic                                   key_busy;
	logic [ROUNDS:0][aes_pkg::BLOCK_W-1:0]  key_sched;
	logic [ROUNDS:0]                        stage_valid;
	logic [ROUNDS:0]                        stage_ready;
	logic [ROUNDS:0][aes_pkg::BLOCK_W-1:0]  stage_state;

	aes_key_expand #(
		.ROUNDS(ROUNDS)
	) u_key_expand (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.busy       (key_busy),
		.key_sched  (key_sched)
	);

	// Entry to the chain: initial key addition on the incoming block.
	assign stage_valid[0] = plain_valid && !key_busy;
	assign stage_state[0] = plain_item ^ key_sched[0];
	assign plain_stall    = key_busy || !stage_ready[0];

	for (genvar g = 1; g <= ROUNDS; g++) begin : g_cell
		aes_round_cell #(
			.LAST(g == ROUNDS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.up_valid  (stage_valid[g-1]),
			.up_state  (stage_state[g-1]),
			.up_ready  (stage_ready[g-1]),
			.stage_key (key_sched[g]),
			.dn_valid  (stage_valid[g]),
			.dn_state  (stage_state[g]),
			.dn_ready  (stage_ready[g])
		);
	end

	// The last cell is the output register.
	assign stage_ready[ROUNDS] = !cipher_stall;
	assign cipher_valid        = stage_valid[ROUNDS];
	assign cipher_item         = stage_state[ROUNDS];

`ifndef NO_ASSERTIONS
	// A key write blocks new items while the round keys are rebuilt.
	a_key_write_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && (cfg_index == aes_pkg::CFG_KEY_WORD_0 ||
		cfg_index == aes_pkg::CFG_KEY_WORD_1 || cfg_index == aes_pkg::CFG_KEY_WORD_2 ||
		cfg_index == aes_pkg::CFG_KEY_WORD_3) |=> plain_stall)
		else $error("item could be taken during key expansion");

	// With every cell full and the output stalled, the input must stall.
	a_full_chain_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(&stage_valid[ROUNDS:1]) && cipher_stall |-> plain_stall)
		else $error("full chain accepted an item");

	// A result appears only when the cell before the last held an item.
	a_result_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cipher_valid) |-> $past(stage_valid[ROUNDS-1]))
		else $error("result appeared without a source item");
`endif

endmodule

`default_nettype wire

// ===== src/aes_key_expand.sv =====
`default_nettype none

module aes_key_expand #(
	parameter int ROUNDS = aes_pkg::ROUNDS_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [aes_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire logic [aes_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                       busy,
	output logic [ROUNDS:0][aes_pkg::BLOCK_W-1:0]      key_sched
);

	localparam int CNT_W = $clog2(ROUNDS + 1);

	logic [aes_pkg::HALF_W-1:0]  key_q [aes_pkg::NUM_KEY_REGS];
	logic [aes_pkg::BLOCK_W-1:0] rk_q [2:ROUNDS];
	logic [aes_pkg::BLOCK_W-1:0] older_q, newer_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic [7:0]                  rcon_q;
	logic                        key_hit;

	logic [aes_pkg::BLOCK_W-1:0] older, newer, next_rk;
	logic [aes_pkg::WORD_W-1:0]  t, w0, w1, w2, w3;

	// A write to one of the key registers restarts the expansion.
	always_comb begin
		case (cfg_index)
			aes_pkg::CFG_KEY_WORD_0,
			aes_pkg::CFG_KEY_WORD_1,
			aes_pkg::CFG_KEY_WORD_2,
			aes_pkg::CFG_KEY_WORD_3: key_hit = cfg_wr_en;
			default:                 key_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aes_pkg::NUM_KEY_REGS; i++) begin
				key_q[i] <= '0;
			end
		end else if (key_hit) begin
			key_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	// The first step works straight from the key registers.
	assign older = (cnt_q == CNT_W'(2)) ? {key_q[0], key_q[1]} : older_q;
	assign newer = (cnt_q == CNT_W'(2)) ? {key_q[2], key_q[3]} : newer_q;

	// Next round key from the two before it: even rounds rotate and add Rcon.
	always_comb begin
		if (!cnt_q[0]) begin
			t = aes_pkg::sub_word({newer[23:0], newer[31:24]}) ^ {rcon_q, 24'h0};
		end else begin
			t = aes_pkg::sub_word(newer[31:0]);
		end
		w0 = older[127:96] ^ t;
		w1 = older[95:64]  ^ w0;
		w2 = older[63:32]  ^ w1;
		w3 = older[31:0]   ^ w2;
		next_rk = {w0, w1, w2, w3};
	end

	// Sequencer: one round key per cycle, starting over after reset or a key write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(2);
			rcon_q <= aes_pkg::RCON_INIT;
		end else if (key_hit) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(2);
			rcon_q <= aes_pkg::RCON_INIT;
		end else if (busy_q) begin
			if (cnt_q == CNT_W'(ROUNDS)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
			if (!cnt_q[0]) begin
				rcon_q <= aes_pkg::xtime(rcon_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !key_hit) begin
			rk_q[cnt_q] <= next_rk;
			older_q     <= newer;
			newer_q     <= next_rk;
		end
	end

	assign busy = busy_q;
	assign key_sched[0] = {key_q[0], key_q[1]};
	assign key_sched[1] = {key_q[2], key_q[3]};

	for (genvar g = 2; g <= ROUNDS; g++) begin : g_rk
		assign key_sched[g] = rk_q[g];
	end

endmodule

`default_nettype wire

// ===== src/aes_round_cell.sv =====
`default_nettype none

module aes_round_cell #(
	parameter bit LAST = 1'b0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          up_valid,
	input  wire logic [aes_pkg::BLOCK_W-1:0]   up_state,
	output logic                               up_ready,
	input  wire logic [aes_pkg::BLOCK_W-1:0]   stage_key,
	output logic                               dn_valid,
	output logic [aes_pkg::BLOCK_W-1:0]        dn_state,
	input  wire logic                          dn_ready
);

	logic                        valid_q;
	logic [aes_pkg::BLOCK_W-1:0] state_q;
	logic                        load;

	// The cell takes a new item when it is empty or its item moves on.
	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// One full round per cell; the final round leaves out the column mix.
	always_ff @(posedge clk) begin
		if (load) begin
			state_q <= aes_pkg::enc_round(up_state, !LAST) ^ stage_key;
		end
	end

	assign dn_valid = valid_q;
	assign dn_state = state_q;

endmodule

`default_nettype wire
